@@ hdl/sha384_message_hasher_unit_assert.svh @@
// Assertion macros for the SHA-384 hasher
`ifndef SHA384_MESSAGE_HASHER_UNIT_ASSERT_SVH
`define SHA384_MESSAGE_HASHER_UNIT_ASSERT_SVH
// Check that an implication holds on every clock edge outside reset
`define SHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle
`define SHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ hdl/sha_pkg.sv @@
`default_nettype none
package sha_pkg;
    localparam int unsigned QDEPTH = 4;

    typedef logic [63:0] t_word;

    // Work item that the front hands to the compression engine
    typedef struct packed {
        logic [15:0][63:0] block;
        logic              last;
    } t_blk;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_eng_state;

    typedef enum logic [1:0] {
        FS_TAKE,
        FS_PAD,
        FS_PUSH
    } t_front_state;

    function automatic t_word round_k(input logic [6:0] j);
        t_word k;
        case (j)
            7'd0: k = 64'h428a2f98d728ae22; 7'd1: k = 64'h7137449123ef65cd;
            7'd2: k = 64'hb5c0fbcfec4d3b2f; 7'd3: k = 64'he9b5dba58189dbbc;
            7'd4: k = 64'h3956c25bf348b538; 7'd5: k = 64'h59f111f1b605d019;
            7'd6: k = 64'h923f82a4af194f9b; 7'd7: k = 64'hab1c5ed5da6d8118;
            7'd8: k = 64'hd807aa98a3030242; 7'd9: k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
            default: k = '0;
        endcase
        return k;
    endfunction

    function automatic t_word init_hv(input logic [2:0] j);
        t_word h;
        case (j)
            3'd0: h = 64'hcbbb9d5dc1059ed8; 3'd1: h = 64'h629a292a367cd507;
            3'd2: h = 64'h9159015a3070dd17; 3'd3: h = 64'h152fecd8f70e5939;
            3'd4: h = 64'h67332667ffc00b31; 3'd5: h = 64'h8eb44a8768581511;
            3'd6: h = 64'hdb0c2e0d64f98fa7; 3'd7: h = 64'h47b5481dbefa4fa4;
            default: h = '0;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction
endpackage
`default_nettype wire

@@ hdl/sha384_message_hasher_unit.sv @@
`default_nettype none
// SHA-384 message hasher.
// Input: pulse i_start with a 64-bit big-endian word, its byte count (0..8,
// larger counts mean 8) and a last flag; the word is taken at an edge where
// i_start is high and o_busy is low. Bytes are packed without gaps.
// A front stage packs bytes into 128-byte blocks and pads the final one;
// full blocks go through a four-deep queue to a compression engine that runs
// one round a cycle, with a load step, 80 rounds and an add step per block.
// Throughput over a long message is set by that engine. The front takes a
// word per cycle while o_busy is low; it raises o_busy while it pushes a
// block (which waits while the queue is full), while it builds a second
// padding block, and from the last word until the digest is out.
// After the last word the six digest words appear on o_digest_word with
// o_word_index 0..5, one per cycle while o_valid is high, o_digest_done on
// the sixth. The receiver cannot stall; results go out as they are made.
// Reset clears the queue and loads the initial values.
module sha384_message_hasher_unit import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_valid,
    output logic [63:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_digest_done
);
    `include "sha384_message_hasher_unit_assert.svh"

    logic f_busy, push, pop, empty, full, eng_idle;
    t_blk fblk, qblk;

    // Hold off a new message until the previous digest is out
    logic r_wait;
    assign o_busy = f_busy || r_wait;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_wait <= 1'b0;
        else if (i_start && !o_busy && i_last_word) r_wait <= 1'b1;
        else if (o_digest_done) r_wait <= 1'b0;
    end

    sha_front u_front (
        .i_clk, .i_rst_n,
        .i_take(i_start && !o_busy),
        .i_data_word, .i_byte_count, .i_last_word,
        .o_busy(f_busy), .o_push(push), .o_blk(fblk), .i_full(full)
    );

    sha_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_blk(fblk), .i_pop(pop),
        .o_blk(qblk), .o_empty(empty), .o_full(full)
    );

    sha_engine u_engine (
        .i_clk, .i_rst_n, .i_empty(empty), .i_blk(qblk), .o_pop(pop),
        .o_idle(eng_idle), .o_valid, .o_digest_word, .o_word_index, .o_digest_done
    );

    `SHA_ASSERT_IMP(a_done_valid, i_clk, i_rst_n, o_digest_done, o_valid)
    `SHA_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, pop, eng_idle && !empty)
    `SHA_ASSERT_IMP(a_no_ovf, i_clk, i_rst_n, push, !full)
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && !o_digest_done,
        o_valid && (o_word_index == $past(o_word_index) + 3'd1))
endmodule
`default_nettype wire

@@ hdl/sha_front.sv @@
`default_nettype none
// Pack message bytes into blocks, pad the last one and push blocks to the queue
module sha_front import sha_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_take,
    input  wire logic [63:0] i_data_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_busy,
    output logic             o_push,
    output t_blk             o_blk,
    input  wire logic        i_full
);
    t_front_state r_st, n_st;
    logic [15:0][63:0] r_buf, n_buf;
    logic [63:0] r_spill, n_spill;
    logic [6:0]  r_fill, n_fill;
    logic [63:0] r_total, n_total;
    logic        r_last, n_last;
    logic        r_fin, n_fin;

    logic [3:0]  cnt;
    logic [3:0]  padoff;
    logic [7:0]  sum;
    logic [127:0] wide, merged, placed;
    logic [6:0]  woff;
    logic [3:0]  wi;
    logic [63:0] tot_n;

    // Clamp the count and place the word at the fill position
    always_comb begin
        cnt = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        sum = {1'b0, r_fill} + {4'd0, cnt};
        wi = r_fill[6:3];
        woff = {1'b0, r_fill[2:0], 3'd0};
        padoff = {1'b0, r_fill[2:0]} + cnt;
        wide = {i_data_word & ~(64'hffff_ffff_ffff_ffff >> {cnt, 3'd0}), 64'd0} >> woff;
        merged = ({r_buf[wi], 64'd0} & ~({64'hffff_ffff_ffff_ffff, 64'd0} >> woff)) | wide;
        // append the pad byte straight after the data on the last word
        placed = i_last_word ? (merged | ({8'h80, 120'd0} >> {padoff, 3'd0})) : merged;
        tot_n = r_total + {60'd0, cnt};
    end

    // Sequence: take a word, push a full block, pad at message end
    always_comb begin
        n_st = r_st;
        case (r_st)
            FS_TAKE: if (i_take && (sum[7] || i_last_word)) n_st = FS_PUSH;
            FS_PAD:  n_st = FS_PUSH;
            FS_PUSH: if (!i_full) n_st = r_fin ? FS_TAKE : (r_last ? FS_PAD : FS_TAKE);
            default: n_st = FS_TAKE;
        endcase
    end

    always_comb begin
        o_busy = (r_st != FS_TAKE);
        o_push = (r_st == FS_PUSH) && !i_full;
        o_blk.block = r_buf;
        o_blk.last = r_fin;
    end

    // Next block contents, fill level and length
    always_comb begin
        n_buf = r_buf;
        n_spill = r_spill;
        n_fill = r_fill;
        n_total = r_total;
        n_last = r_last;
        n_fin = r_fin;
        case (r_st)
            FS_TAKE: if (i_take) begin
                n_total = tot_n;
                n_fill = sum[6:0];
                n_last = i_last_word;
                n_fin = 1'b0;
                // clear the words after the data when the message ends
                if (i_last_word)
                    for (int k = 0; k < 16; k++)
                        if (k > int'(wi)) n_buf[k] = '0;
                n_buf[wi] = placed[127:64];
                if (wi != 4'd15) n_buf[wi + 4'd1] = placed[63:0];
                // hold bytes past the end of the block for the next one
                n_spill = sum[7] ? placed[63:0] : 64'd0;
                // put the length here when it fits
                if (i_last_word && !sum[7] && (sum[6:0] < 7'd112)) begin
                    n_buf[14] = {61'd0, tot_n[63:61]};
                    n_buf[15] = {tot_n[60:0], 3'd0};
                    n_fin = 1'b1;
                end
            end
            FS_PAD: begin
                // second block: spilled bytes and pad, zero fill, then the length
                n_buf[0] = r_spill;
                for (int k = 1; k < 14; k++) n_buf[k] = '0;
                n_buf[14] = {61'd0, r_total[63:61]};
                n_buf[15] = {r_total[60:0], 3'd0};
                n_fin = 1'b1;
            end
            FS_PUSH: if (!i_full) begin
                // start the next block with the bytes that spilled over
                n_buf[0] = r_spill;
                if (r_fin) begin
                    n_fill = '0;
                    n_total = '0;
                    n_last = 1'b0;
                    n_fin = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= FS_TAKE;
            r_spill <= '0;
            r_fill <= '0;
            r_total <= '0;
            r_last <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            r_st <= n_st;
            r_spill <= n_spill;
            r_fill <= n_fill;
            r_total <= n_total;
            r_last <= n_last;
            r_fin <= n_fin;
        end
    end
endmodule
`default_nettype wire

@@ hdl/sha_queue.sv @@
`default_nettype none
// Short block queue between front and engine
module sha_queue import sha_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_blk      i_blk,
    input  wire logic i_pop,
    output t_blk      o_blk,
    output logic      o_empty,
    output logic      o_full
);
    t_blk r_mem [QDEPTH];
    logic [$clog2(QDEPTH)-1:0] r_wp, r_rp;
    logic [$clog2(QDEPTH):0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == ($clog2(QDEPTH)+1)'(QDEPTH));
    assign o_blk   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_blk;
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + ($clog2(QDEPTH))'(1);
            if (i_pop)  r_rp <= r_rp + ($clog2(QDEPTH))'(1);
            r_cnt <= r_cnt + {{$clog2(QDEPTH){1'b0}}, i_push}
                           - {{$clog2(QDEPTH){1'b0}}, i_pop};
        end
    end
endmodule
`default_nettype wire

@@ hdl/sha_engine.sv @@
`default_nettype none
// Run 80 rounds per block, one a cycle, and emit the digest after the last block
module sha_engine import sha_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  t_blk       i_blk,
    output logic       o_pop,
    output logic       o_idle,
    output logic       o_valid,
    output logic [63:0] o_digest_word,
    output logic [2:0] o_word_index,
    output logic       o_digest_done
);
    t_eng_state r_st, n_st;
    logic [7:0][63:0]  r_h, r_v;
    logic [15:0][63:0] r_w;
    logic [6:0] r_rnd;
    logic [2:0] r_oi;
    logic       r_last;
    logic       r_val;
    logic [63:0] r_dw;
    logic [2:0]  r_di;

    logic [63:0] t1, t2, s0, s1, wn;

    // One round and one schedule step
    always_comb begin
        t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_rnd) + r_w[0];
        t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
        s0 = rotr(r_w[1], 1) ^ rotr(r_w[1], 8) ^ (r_w[1] >> 7);
        s1 = rotr(r_w[14], 19) ^ rotr(r_w[14], 61) ^ (r_w[14] >> 6);
        wn = s1 + r_w[9] + s0 + r_w[0];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE:  if (!i_empty) n_st = ST_ROUND;
            ST_ROUND: if (r_rnd == 7'd79) n_st = ST_ADD;
            ST_ADD:   n_st = r_last ? ST_OUT : ST_IDLE;
            ST_OUT:   if (r_oi == 3'd5) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop = (r_st == ST_IDLE) && !i_empty;
        o_idle = (r_st == ST_IDLE);
        o_valid = r_val;
        o_digest_word = r_dw;
        o_word_index = r_di;
        o_digest_done = r_val && (r_di == 3'd5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_rnd <= '0;
            r_oi <= '0;
            r_val <= 1'b0;
            r_last <= 1'b0;
            for (int k = 0; k < 8; k++) r_h[k] <= init_hv(3'(k));
        end else begin
            r_st <= n_st;
            r_val <= (r_st == ST_OUT);
            r_di <= r_oi;
            r_dw <= r_h[r_oi];
            case (r_st)
                ST_IDLE: if (!i_empty) begin
                    r_w <= i_blk.block;
                    r_v <= r_h;
                    r_last <= i_blk.last;
                    r_rnd <= '0;
                end
                ST_ROUND: begin
                    r_v <= {r_v[6], r_v[5], r_v[4], r_v[3] + t1,
                            r_v[2], r_v[1], r_v[0], t1 + t2};
                    r_w <= {wn, r_w[15:1]};
                    r_rnd <= r_rnd + 7'd1;
                end
                ST_ADD: begin
                    for (int k = 0; k < 8; k++) r_h[k] <= r_h[k] + r_v[k];
                    r_oi <= '0;
                end
                ST_OUT: begin
                    r_oi <= r_oi + 3'd1;
                    if (r_oi == 3'd5)
                        for (int k = 0; k < 8; k++) r_h[k] <= init_hv(3'(k));
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
